/* sv/assert_macros.svh */
// Assertion macros used by the checker file of the maze walker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define RHWF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RHWF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/rhwf_pkg.sv */
// Types, codes, constants and helper functions of the right-hand wall follower.
`default_nettype none
package rhwf_pkg;

   // Field widths.
   localparam int POS_W        = 4;
   localparam int HEAD_W       = 2;
   localparam int FUNC_W       = 2;
   localparam int STEP_COUNT_W = 20;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 32;

   // Default sizes of the storage and the step counter.
   localparam int MAX_ROWS_DEF  = 16;
   localparam int MAX_COLS_DEF  = 16;
   localparam int STEP_BITS_DEF = 20;

   // Function codes of an input word.
   localparam logic [FUNC_W-1:0] F_LOAD    = 2'd0;
   localparam logic [FUNC_W-1:0] F_RESTART = 2'd1;
   localparam logic [FUNC_W-1:0] F_STEP    = 2'd2;

   // Headings.
   localparam logic [HEAD_W-1:0] DIR_N = 2'd0;
   localparam logic [HEAD_W-1:0] DIR_E = 2'd1;
   localparam logic [HEAD_W-1:0] DIR_S = 2'd2;
   localparam logic [HEAD_W-1:0] DIR_W = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_MAZE_ROWS  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAZE_COLS  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_ROW  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_COL  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_GOAL_CELLS = 3'd4;

   // Configuration reset values.
   localparam logic [4:0]            MAZE_ROWS_RST  = 5'd16;
   localparam logic [4:0]            MAZE_COLS_RST  = 5'd16;
   localparam logic [POS_W-1:0]      START_ROW_RST  = 4'd0;
   localparam logic [POS_W-1:0]      START_COL_RST  = 4'd0;
   localparam logic [CSR_DATA_W-1:0] GOAL_CELLS_RST = 32'h8887_7877;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;   // a word is taken this cycle: read the wall memory
      logic load;     // a load word is taken this cycle: write the wall memory
      logic exec;     // update cycle
      logic restart;  // update cycle of a restart word
      logic step;     // update cycle of a step word
   } rhwf_cmd_type;

   // Wall bit that guards the given side: south bit for north and south, east bit otherwise.
   function automatic logic wall_bit(input logic [HEAD_W-1:0] dir, input logic [1:0] walls);
      logic bit_v;
      bit_v = ((dir == DIR_N) || (dir == DIR_S)) ? walls[1] : walls[0];
      return bit_v;
   endfunction

   // True when a move in the given direction stays inside the maze in use.
   function automatic logic border_ok(input logic [HEAD_W-1:0] dir,
                                      input logic [POS_W-1:0] row,
                                      input logic [POS_W-1:0] col,
                                      input logic [4:0] rows_used,
                                      input logic [4:0] cols_used);
      logic ok;
      unique case (dir)
         DIR_N: ok = (row != '0);
         DIR_E: ok = (({1'b0, col} + 5'd1) < cols_used);
         DIR_S: ok = (({1'b0, row} + 5'd1) < rows_used);
         DIR_W: ok = (col != '0);
      endcase
      return ok;
   endfunction

   // Row after one move in the given direction, wrapping in four bits.
   function automatic logic [POS_W-1:0] move_row(input logic [HEAD_W-1:0] dir,
                                                 input logic [POS_W-1:0] row);
      logic [POS_W-1:0] r;
      r = row;
      if (dir == DIR_N) r = row - 4'd1;
      else if (dir == DIR_S) r = row + 4'd1;
      return r;
   endfunction

   // Column after one move in the given direction, wrapping in four bits.
   function automatic logic [POS_W-1:0] move_col(input logic [HEAD_W-1:0] dir,
                                                 input logic [POS_W-1:0] col);
      logic [POS_W-1:0] c;
      c = col;
      if (dir == DIR_E) c = col + 4'd1;
      else if (dir == DIR_W) c = col - 4'd1;
      return c;
   endfunction

   // True when the cell matches any of the four goal bytes.
   function automatic logic goal_hit(input logic [POS_W-1:0] row,
                                     input logic [POS_W-1:0] col,
                                     input logic [CSR_DATA_W-1:0] goals);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k < 4; k++) begin
         if ((goals[8*k+4 +: 4] == row) && (goals[8*k +: 4] == col)) hit = 1'b1;
      end
      return hit;
   endfunction

endpackage
`default_nettype wire

/* sv/rhwf_ctrl.sv */
// Controller of the maze walker: accepts words and sequences the update cycle.
`default_nettype none
module rhwf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             req_func,
   output logic                   busy,
   output logic                   rsp_valid,
   output rhwf_pkg::rhwf_cmd_type cmd
);
   import rhwf_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic              state_ff, state_in;
   logic [FUNC_W-1:0] func_ff, func_in;
   logic              rsp_valid_ff;
   logic              accept;

   assign accept = start && (state_ff == ST_IDLE);

   always_comb begin
      unique case (state_ff)
         ST_IDLE: state_in = accept ? ST_EXEC : ST_IDLE;
         ST_EXEC: state_in = ST_IDLE;
      endcase
      func_in = accept ? req_func : func_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         func_ff      <= F_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         func_ff      <= func_in;
         rsp_valid_ff <= (state_ff == ST_EXEC);
      end
   end

   always_comb begin
      cmd.accept  = accept;
      cmd.load    = accept && (req_func == F_LOAD);
      cmd.exec    = (state_ff == ST_EXEC);
      cmd.restart = (state_ff == ST_EXEC) && (func_ff == F_RESTART);
      cmd.step    = (state_ff == ST_EXEC) && (func_ff == F_STEP);
   end

   assign busy      = (state_ff == ST_EXEC);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

/* sv/rhwf_dp.sv */
// Datapath of the maze walker: registers, wall memory and the step rule.
`default_nettype none
module rhwf_dp #(
   parameter int MAX_ROWS  = rhwf_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS  = rhwf_pkg::MAX_COLS_DEF,
   parameter int STEP_BITS = rhwf_pkg::STEP_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  rhwf_pkg::rhwf_cmd_type                cmd,
   input  logic [rhwf_pkg::POS_W-1:0]            req_cell_row,
   input  logic [rhwf_pkg::POS_W-1:0]            req_cell_col,
   input  logic                                  req_east_wall,
   input  logic                                  req_south_wall,
   input  logic                                  csr_we,
   input  logic [rhwf_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [rhwf_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output logic [rhwf_pkg::POS_W-1:0]            rsp_pos_row,
   output logic [rhwf_pkg::POS_W-1:0]            rsp_pos_col,
   output logic [rhwf_pkg::HEAD_W-1:0]           rsp_heading,
   output logic                                  rsp_at_goal,
   output logic [rhwf_pkg::STEP_COUNT_W-1:0]     rsp_step_count
);
   import rhwf_pkg::*;

   localparam int DEPTH   = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int ROW_LIM = (MAX_ROWS < 16) ? MAX_ROWS : 16;
   localparam int COL_LIM = (MAX_COLS < 16) ? MAX_COLS : 16;

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [POS_W-1:0] r,
                                                   input logic [POS_W-1:0] c);
      return ADDR_W'(int'(r) * MAX_COLS + int'(c));
   endfunction

   // Configuration registers.
   logic [4:0]            rows_ff, cols_ff;
   logic [POS_W-1:0]      srow_ff, scol_ff;
   logic [CSR_DATA_W-1:0] goal_ff;

   // Walker state.
   logic [POS_W-1:0]     row_ff, row_in, col_ff, col_in;
   logic [HEAD_W-1:0]    head_ff, head_in;
   logic [STEP_BITS-1:0] steps_ff, steps_in;
   logic                 at_goal_ff;

   // Wall memory and its read registers.
   logic [1:0]  wall_mem [0:DEPTH-1];
   logic [1:0]  wall_a_ff, wall_b_ff;
   logic        store_a_ff, store_b_ff;

   logic [HEAD_W-1:0] dir_a, dir_b;
   logic [POS_W-1:0]  rd_row_a, rd_col_a, rd_row_b, rd_col_b;
   logic              in_a, in_b, load_in;
   logic [ADDR_W-1:0] addr_a, addr_b, load_addr;

   logic [4:0]        rows_used, cols_used, last_row, last_col;
   logic              open_a, open_b, goal_now;

   // Read side: port A serves the right-hand side, port B the front.
   always_comb begin
      dir_a    = head_ff + 2'd1;
      dir_b    = head_ff;
      rd_row_a = (dir_a == DIR_N) ? row_ff - 4'd1 : row_ff;
      rd_col_a = (dir_a == DIR_W) ? col_ff - 4'd1 : col_ff;
      rd_row_b = (dir_b == DIR_N) ? row_ff - 4'd1 : row_ff;
      rd_col_b = (dir_b == DIR_W) ? col_ff - 4'd1 : col_ff;
      in_a     = (int'(rd_row_a) < MAX_ROWS) && (int'(rd_col_a) < MAX_COLS);
      in_b     = (int'(rd_row_b) < MAX_ROWS) && (int'(rd_col_b) < MAX_COLS);
      addr_a   = in_a ? cell_addr(rd_row_a, rd_col_a) : '0;
      addr_b   = in_b ? cell_addr(rd_row_b, rd_col_b) : '0;
      load_in  = (int'(req_cell_row) < MAX_ROWS) && (int'(req_cell_col) < MAX_COLS);
      load_addr = load_in ? cell_addr(req_cell_row, req_cell_col) : '0;
   end

   always_ff @(posedge clock) begin
      if (cmd.load && load_in) begin
         wall_mem[load_addr] <= {req_south_wall, req_east_wall};
      end
      if (cmd.accept) begin
         wall_a_ff  <= wall_mem[addr_a];
         wall_b_ff  <= wall_mem[addr_b];
         store_a_ff <= in_a;
         store_b_ff <= in_b;
      end
   end

   // Sizes in use, clamped to one and to the storage.
   always_comb begin
      if (rows_ff == '0) rows_used = 5'd1;
      else if (rows_ff > 5'(ROW_LIM)) rows_used = 5'(ROW_LIM);
      else rows_used = rows_ff;
      if (cols_ff == '0) cols_used = 5'd1;
      else if (cols_ff > 5'(COL_LIM)) cols_used = 5'(COL_LIM);
      else cols_used = cols_ff;
      last_row = rows_used - 5'd1;
      last_col = cols_used - 5'd1;
   end

   // Restart and step rule; a side outside storage counts as walled.
   always_comb begin
      open_a   = border_ok(dir_a, row_ff, col_ff, rows_used, cols_used) && store_a_ff
                 && !wall_bit(dir_a, wall_a_ff);
      open_b   = border_ok(dir_b, row_ff, col_ff, rows_used, cols_used) && store_b_ff
                 && !wall_bit(dir_b, wall_b_ff);
      goal_now = goal_hit(row_ff, col_ff, goal_ff);
      row_in   = row_ff;
      col_in   = col_ff;
      head_in  = head_ff;
      steps_in = steps_ff;
      if (cmd.restart) begin
         row_in   = ({1'b0, srow_ff} > last_row) ? last_row[POS_W-1:0] : srow_ff;
         col_in   = ({1'b0, scol_ff} > last_col) ? last_col[POS_W-1:0] : scol_ff;
         head_in  = DIR_E;
         steps_in = '0;
      end else if (cmd.step && !goal_now) begin
         if (open_a) begin
            head_in = dir_a;
            row_in  = move_row(dir_a, row_ff);
            col_in  = move_col(dir_a, col_ff);
         end else if (open_b) begin
            row_in  = move_row(dir_b, row_ff);
            col_in  = move_col(dir_b, col_ff);
         end else begin
            head_in = head_ff - 2'd1;
         end
         if (steps_ff != '1) steps_in = steps_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff    <= MAZE_ROWS_RST;
         cols_ff    <= MAZE_COLS_RST;
         srow_ff    <= START_ROW_RST;
         scol_ff    <= START_COL_RST;
         goal_ff    <= GOAL_CELLS_RST;
         row_ff     <= '0;
         col_ff     <= '0;
         head_ff    <= DIR_E;
         steps_ff   <= '0;
         at_goal_ff <= goal_hit('0, '0, GOAL_CELLS_RST);
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_MAZE_ROWS:  rows_ff <= csr_wdata[4:0];
               CSR_MAZE_COLS:  cols_ff <= csr_wdata[4:0];
               CSR_START_ROW:  srow_ff <= csr_wdata[POS_W-1:0];
               CSR_START_COL:  scol_ff <= csr_wdata[POS_W-1:0];
               CSR_GOAL_CELLS: goal_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.exec) begin
            row_ff     <= row_in;
            col_ff     <= col_in;
            head_ff    <= head_in;
            steps_ff   <= steps_in;
            at_goal_ff <= goal_hit(row_in, col_in, goal_ff);
         end
      end
   end

   logic [STEP_BITS+STEP_COUNT_W-1:0] steps_wide;
   assign steps_wide = {{STEP_COUNT_W{1'b0}}, steps_ff};

   assign rsp_pos_row    = row_ff;
   assign rsp_pos_col    = col_ff;
   assign rsp_heading    = head_ff;
   assign rsp_at_goal    = at_goal_ff;
   assign rsp_step_count = steps_wide[STEP_COUNT_W-1:0];

endmodule
`default_nettype wire

/* sv/right_hand_wall_follower.sv */
// Top level of the right-hand-rule maze walker.
// A word accepted at an edge moves the controller into its update state, in which
// busy is high and the walker registers are updated; the result strobe on rsp_valid
// is registered from that state. The wall memory is read through a registered read
// when the word is accepted, and no new word is taken while busy is high.
// Reset (synchronous, active high) restores the configuration defaults and puts the
// walker at row 0, column 0, facing east, with a step count of zero.
`default_nettype none
module right_hand_wall_follower #(
   parameter int MAX_ROWS  = rhwf_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS  = rhwf_pkg::MAX_COLS_DEF,
   parameter int STEP_BITS = rhwf_pkg::STEP_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [rhwf_pkg::FUNC_W-1:0]       req_func,
   input  logic [rhwf_pkg::POS_W-1:0]        req_cell_row,
   input  logic [rhwf_pkg::POS_W-1:0]        req_cell_col,
   input  logic                              req_east_wall,
   input  logic                              req_south_wall,
   output logic                              rsp_valid,
   output logic [rhwf_pkg::POS_W-1:0]        rsp_pos_row,
   output logic [rhwf_pkg::POS_W-1:0]        rsp_pos_col,
   output logic [rhwf_pkg::HEAD_W-1:0]       rsp_heading,
   output logic                              rsp_at_goal,
   output logic [rhwf_pkg::STEP_COUNT_W-1:0] rsp_step_count,
   input  logic                              csr_we,
   input  logic [rhwf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [rhwf_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import rhwf_pkg::*;

   // The controller owns the handshake; the datapath holds every register the
   // result word is read from, so the result ports stay steady between updates.
   rhwf_cmd_type cmd;

   rhwf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_func  (req_func),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // The wall memory is read at the accepting edge at the two cells that bound the
   // walker's right-hand side and front; the following edge applies the rule.
   rhwf_dp #(
      .MAX_ROWS  (MAX_ROWS),
      .MAX_COLS  (MAX_COLS),
      .STEP_BITS (STEP_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_cell_row   (req_cell_row),
      .req_cell_col   (req_cell_col),
      .req_east_wall  (req_east_wall),
      .req_south_wall (req_south_wall),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_pos_row    (rsp_pos_row),
      .rsp_pos_col    (rsp_pos_col),
      .rsp_heading    (rsp_heading),
      .rsp_at_goal    (rsp_at_goal),
      .rsp_step_count (rsp_step_count)
   );

endmodule
`default_nettype wire

/* sv/rhwf_checker.sv */
// Port-level checker of the maze walker and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"
module rhwf_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic [rhwf_pkg::FUNC_W-1:0]       req_func,
   input logic                              rsp_valid,
   input logic [rhwf_pkg::POS_W-1:0]        rsp_pos_row,
   input logic [rhwf_pkg::POS_W-1:0]        rsp_pos_col,
   input logic [rhwf_pkg::HEAD_W-1:0]       rsp_heading,
   input logic [rhwf_pkg::STEP_COUNT_W-1:0] rsp_step_count
);
   import rhwf_pkg::*;

   // Every accepted word is busy for one cycle and then strobes exactly one result.
   `RHWF_ASSERT_NXT(a_word_result, clock, reset, start && !busy, busy ##1 rsp_valid, "accepted word gave no result two cycles later")

   // Results never come back to back.
   `RHWF_ASSERT_NXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid, "result strobe lasted more than one cycle")

   // A restart always reports an east heading and a zero count.
   `RHWF_ASSERT_NXT(a_restart_state, clock, reset, start && !busy && req_func == F_RESTART, ##1 (rsp_heading == DIR_E && rsp_step_count == '0), "restart result not at east with zero count")

   // A load leaves the walker where it stands.
   `RHWF_ASSERT_NXT(a_load_holds, clock, reset, start && !busy && req_func == F_LOAD, ##1 ($stable(rsp_pos_row) && $stable(rsp_pos_col) && $stable(rsp_heading) && $stable(rsp_step_count)), "load word moved the walker")

endmodule

bind right_hand_wall_follower rhwf_checker u_rhwf_checker (.*);
`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for the right-hand-rule maze walker with a built-in walker predictor.
`timescale 1ns / 1ps
module testbench;
   import rhwf_pkg::*;

   // Clock, reset and run shape.
   localparam int HALF_NS      = 10;
   localparam int RESET_CYCLES = 6;
   localparam int TAIL_CYCLES  = 8;
   localparam int RANDOM_WORDS = 1000;
   localparam int MAX_REPORTS  = 100;

   // The step counter is exactly as wide as the result field, so it saturates at all ones.
   localparam logic [STEP_COUNT_W-1:0] STEP_SAT = '1;

   // The one function code that the block defines as doing nothing.
   localparam logic [FUNC_W-1:0] F_UNUSED = 2'd3;

   // One result word as the predictor expects it.
   typedef struct packed {
      logic [POS_W-1:0]        row;
      logic [POS_W-1:0]        col;
      logic [HEAD_W-1:0]       heading;
      logic                    at_goal;
      logic [STEP_COUNT_W-1:0] steps;
   } walker_view_type;

   // Every input of the block has a known value from time zero on.
   logic                    clock          = 1'b0;
   logic                    reset          = 1'b1;
   logic                    start          = 1'b0;
   logic [FUNC_W-1:0]       req_func       = F_RESTART;
   logic [POS_W-1:0]        req_cell_row   = '0;
   logic [POS_W-1:0]        req_cell_col   = '0;
   logic                    req_east_wall  = 1'b0;
   logic                    req_south_wall = 1'b0;
   logic                    csr_we         = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index      = CSR_MAZE_ROWS;
   logic [CSR_DATA_W-1:0]   csr_wdata      = '0;
   logic                    busy;
   logic                    rsp_valid;
   logic [POS_W-1:0]        rsp_pos_row;
   logic [POS_W-1:0]        rsp_pos_col;
   logic [HEAD_W-1:0]       rsp_heading;
   logic                    rsp_at_goal;
   logic [STEP_COUNT_W-1:0] rsp_step_count;

   right_hand_wall_follower dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_cell_row   (req_cell_row),
      .req_cell_col   (req_cell_col),
      .req_east_wall  (req_east_wall),
      .req_south_wall (req_south_wall),
      .rsp_valid      (rsp_valid),
      .rsp_pos_row    (rsp_pos_row),
      .rsp_pos_col    (rsp_pos_col),
      .rsp_heading    (rsp_heading),
      .rsp_at_goal    (rsp_at_goal),
      .rsp_step_count (rsp_step_count),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #HALF_NS clock = 1'b1;
      #HALF_NS clock = 1'b0;
   end

   // The predictor keeps its own copy of the wall memory (bit 0 east, bit 1 south), of the
   // configuration registers and of the walker.
   logic [1:0]            wall_bits [0:255];
   logic [4:0]            cfg_rows;
   logic [4:0]            cfg_cols;
   logic [POS_W-1:0]      cfg_start_row;
   logic [POS_W-1:0]      cfg_start_col;
   logic [CSR_DATA_W-1:0] cfg_goals;
   logic [POS_W-1:0]        walk_row;
   logic [POS_W-1:0]        walk_col;
   logic [HEAD_W-1:0]       walk_dir;
   logic [STEP_COUNT_W-1:0] walk_steps;

   // Result words that have been predicted but not yet seen, oldest first.
   walker_view_type pending_views[$];

   int mismatch_count = 0;
   int words_sent     = 0;
   int burst_left     = 0;

   // A size of zero counts as one, and anything above the 16-cell storage counts as 16.
   function automatic int rows_in_use();
      int n;
      n = int'(cfg_rows);
      if (n < 1) n = 1;
      if (n > 16) n = 16;
      return n;
   endfunction

   function automatic int cols_in_use();
      int n;
      n = int'(cfg_cols);
      if (n < 1) n = 1;
      if (n > 16) n = 16;
      return n;
   endfunction

   // A side is open only if no wall guards it and it is not the border of the maze in use.
   // The north wall is the south wall of the cell above, the west wall the east wall of the
   // cell to the left.
   function automatic logic side_open(input logic [HEAD_W-1:0] dir);
      logic open_v;
      case (dir)
         DIR_N: open_v = (walk_row != '0) && !wall_bits[{walk_row - 4'd1, walk_col}][1];
         DIR_E: open_v = (int'(walk_col) + 1 < cols_in_use()) &&
                         !wall_bits[{walk_row, walk_col}][0];
         DIR_S: open_v = (int'(walk_row) + 1 < rows_in_use()) &&
                         !wall_bits[{walk_row, walk_col}][1];
         default: open_v = (walk_col != '0) && !wall_bits[{walk_row, walk_col - 4'd1}][0];
      endcase
      return open_v;
   endfunction

   function automatic logic on_goal();
      logic hit;
      hit = 1'b0;
      for (int k = 0; k < 4; k++) begin
         if (cfg_goals[8*k+4 +: 4] == walk_row && cfg_goals[8*k +: 4] == walk_col) hit = 1'b1;
      end
      return hit;
   endfunction

   // Applies one accepted word to the predicted state and returns the result it must produce.
   function automatic walker_view_type predict_walk(input logic [FUNC_W-1:0] func,
                                                    input logic [POS_W-1:0] row,
                                                    input logic [POS_W-1:0] col,
                                                    input logic east,
                                                    input logic south);
      logic [HEAD_W-1:0] right_dir;
      logic              moved;
      int                last_row;
      int                last_col;
      walker_view_type   view;
      right_dir = walk_dir + 2'd1;
      moved     = 1'b0;
      last_row  = rows_in_use() - 1;
      last_col  = cols_in_use() - 1;
      case (func)
         F_LOAD: wall_bits[{row, col}] = {south, east};
         F_RESTART: begin
            // A start cell outside the maze is pulled in to the last row and column in use.
            walk_row   = (cfg_start_row > last_row) ? last_row[POS_W-1:0] : cfg_start_row;
            walk_col   = (cfg_start_col > last_col) ? last_col[POS_W-1:0] : cfg_start_col;
            walk_dir   = DIR_E;
            walk_steps = '0;
         end
         F_STEP: begin
            // On a goal cell the walker holds still and the count stays put.
            if (!on_goal()) begin
               if (side_open(right_dir)) begin
                  walk_dir = right_dir;
                  moved    = 1'b1;
               end else if (side_open(walk_dir)) begin
                  moved = 1'b1;
               end else begin
                  walk_dir = walk_dir - 2'd1;
               end
               if (moved) begin
                  case (walk_dir)
                     DIR_N: walk_row = walk_row - 4'd1;
                     DIR_E: walk_col = walk_col + 4'd1;
                     DIR_S: walk_row = walk_row + 4'd1;
                     default: walk_col = walk_col - 4'd1;
                  endcase
               end
               if (walk_steps != STEP_SAT) walk_steps = walk_steps + 1'b1;
            end
         end
         default: ;
      endcase
      view.row     = walk_row;
      view.col     = walk_col;
      view.heading = walk_dir;
      view.at_goal = on_goal();
      view.steps   = walk_steps;
      return view;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_REPORTS) $display("%0t ns  mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // Holds start low for the given number of falling edges.
   task automatic pause(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   // The sender works in bursts; between two bursts it goes quiet for a random gap. Now and
   // then a long burst gives a stretch with no idling at all.
   task automatic pace();
      if (burst_left == 0) begin
         pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
         burst_left = ($urandom_range(0, 7) == 0) ? 48 : $urandom_range(1, 12);
      end
      burst_left--;
   endtask

   // Offers one word and waits for the block to take it. The word is accepted at the first
   // rising edge where busy is low; its result is predicted right there.
   task automatic send_word(input logic [FUNC_W-1:0] func,
                            input logic [POS_W-1:0] row,
                            input logic [POS_W-1:0] col,
                            input logic east,
                            input logic south);
      pace();
      @(negedge clock);
      start          = 1'b1;
      req_func       = func;
      req_cell_row   = row;
      req_cell_col   = col;
      req_east_wall  = east;
      req_south_wall = south;
      do @(posedge clock); while (busy);
      pending_views.push_back(predict_walk(func, row, col, east, south));
      if (func != F_UNUSED) words_sent++;
   endtask

   // A word whose cell and wall fields are don't-cares gets random ones anyway.
   task automatic send_cmd(input logic [FUNC_W-1:0] func);
      send_word(func, 4'($urandom), 4'($urandom), 1'($urandom), 1'($urandom));
   endtask

   // Lowers start, waits until every predicted result has come back, and then pauses with start low.
   task automatic wait_drain();
      pause(1);
      while (pending_views.size() != 0) @(posedge clock);
      pause(4);
   endtask

   // One register write; the predictor copy is updated at the edge that performs it.
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = data;
      @(posedge clock);
      case (index)
         CSR_MAZE_ROWS:  cfg_rows      = data[4:0];
         CSR_MAZE_COLS:  cfg_cols      = data[4:0];
         CSR_START_ROW:  cfg_start_row = data[POS_W-1:0];
         CSR_START_COL:  cfg_start_col = data[POS_W-1:0];
         CSR_GOAL_CELLS: cfg_goals     = data;
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // Writes the whole configuration. The block must be idle, so callers drain first. Half of
   // the time the unused upper bits of the narrow registers carry random junk.
   task automatic set_maze(input logic [4:0] rows,
                           input logic [4:0] cols,
                           input logic [POS_W-1:0] srow,
                           input logic [POS_W-1:0] scol,
                           input logic [CSR_DATA_W-1:0] goals);
      logic [CSR_DATA_W-1:0] junk;
      junk = $urandom_range(0, 1) ? $urandom : '0;
      csr_write(CSR_MAZE_ROWS, {junk[31:5], rows});
      csr_write(CSR_MAZE_COLS, {junk[31:5], cols});
      csr_write(CSR_START_ROW, {junk[31:4], srow});
      csr_write(CSR_START_COL, {junk[31:4], scol});
      csr_write(CSR_GOAL_CELLS, goals);
   endtask

   // Every result word is checked at the rising edge that ends its strobe cycle.
   always @(posedge clock) begin
      walker_view_type want;
      if (!reset && rsp_valid) begin
         if (pending_views.size() == 0) begin
            report_mismatch("result word with no word pending");
         end else begin
            want = pending_views.pop_front();
            if (rsp_pos_row !== want.row)
               report_mismatch($sformatf("pos_row %0d, expected %0d", rsp_pos_row, want.row));
            if (rsp_pos_col !== want.col)
               report_mismatch($sformatf("pos_col %0d, expected %0d", rsp_pos_col, want.col));
            if (rsp_heading !== want.heading)
               report_mismatch($sformatf("heading %0d, expected %0d",
                                         rsp_heading, want.heading));
            if (rsp_at_goal !== want.at_goal)
               report_mismatch($sformatf("at_goal %0b, expected %0b",
                                         rsp_at_goal, want.at_goal));
            if (rsp_step_count !== want.steps)
               report_mismatch($sformatf("step_count %0d, expected %0d",
                                         rsp_step_count, want.steps));
         end
      end
   end

   // Loads every cell of the storage once, so that no later step can read a cell that was
   // never written. The walker itself must stay at its reset position meanwhile.
   task automatic test_fill_map();
      for (int r = 0; r < 16; r++) begin
         for (int c = 0; c < 16; c++) begin
            send_word(F_LOAD, r[POS_W-1:0], c[POS_W-1:0], 1'($urandom), 1'($urandom));
         end
      end
   endtask

   // Steps taken straight out of reset, with no restart, start from row 0, column 0, east.
   task automatic test_step_from_reset();
      send_cmd(F_STEP);
      send_cmd(F_STEP);
   endtask

   // The unused function code changes nothing but still returns a word.
   task automatic test_unused_func();
      send_cmd(F_UNUSED);
      send_word(F_UNUSED, '1, '1, 1'b1, 1'b1);
   endtask

   // In an open 2 x 2 maze the walker first turns right and moves, then finds both right and
   // front closed and turns left, then moves straight ahead.
   task automatic test_rule_moves();
      wait_drain();
      set_maze(5'd2, 5'd2, 4'd0, 4'd0, GOAL_CELLS_RST);
      send_word(F_LOAD, 4'd0, 4'd0, 1'b0, 1'b0);
      send_word(F_LOAD, 4'd0, 4'd1, 1'b0, 1'b0);
      send_word(F_LOAD, 4'd1, 4'd0, 1'b0, 1'b0);
      send_word(F_LOAD, 4'd1, 4'd1, 1'b0, 1'b0);
      send_cmd(F_RESTART);
      repeat (3) send_cmd(F_STEP);
   endtask

   // Sizes of zero give a single cell bounded by the border on all sides, so every step is a
   // left turn in place; the start is pulled back into that cell.
   task automatic test_tiny_maze();
      wait_drain();
      set_maze(5'd0, 5'd0, 4'd5, 4'd9, GOAL_CELLS_RST);
      send_cmd(F_RESTART);
      repeat (4) send_cmd(F_STEP);
   endtask

   // Sizes above the storage saturate to 16, so the far corner is a valid start.
   task automatic test_size_saturation();
      wait_drain();
      set_maze(5'd31, 5'd17, 4'd15, 4'd15, GOAL_CELLS_RST);
      send_cmd(F_RESTART);
      repeat (2) send_cmd(F_STEP);
   endtask

   // A start outside a small maze lands on its last row and column.
   task automatic test_start_clamp();
      wait_drain();
      set_maze(5'd4, 5'd3, 4'd15, 4'd15, GOAL_CELLS_RST);
      send_cmd(F_RESTART);
      send_cmd(F_STEP);
   endtask

   // Restarting on a goal cell reports the goal, and steps there hold still with the count
   // left at zero. Both extreme goal values are used.
   task automatic test_goal_hold();
      wait_drain();
      set_maze(5'd16, 5'd16, 4'd15, 4'd15, '1);
      send_cmd(F_RESTART);
      repeat (2) send_cmd(F_STEP);
      wait_drain();
      set_maze(5'd2, 5'd2, 4'd0, 4'd0, '0);
      send_cmd(F_RESTART);
      send_cmd(F_STEP);
   endtask

   // The maze shrinks while the walker stands outside it; steps still follow the rule.
   task automatic test_shrink_under_walker();
      wait_drain();
      set_maze(5'd16, 5'd16, 4'd9, 4'd9, GOAL_CELLS_RST);
      send_cmd(F_RESTART);
      send_cmd(F_STEP);
      wait_drain();
      set_maze(5'd3, 5'd3, 4'd0, 4'd0, GOAL_CELLS_RST);
      repeat (3) send_cmd(F_STEP);
   endtask

   // Mostly small mazes, with now and then a size of zero, a full 16 or one above it.
   function automatic logic [4:0] pick_extent();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return 5'd0;
      if (roll == 1) return 5'($urandom_range(17, 31));
      if (roll <= 3) return 5'd16;
      if (roll == 4) return 5'd1;
      return 5'($urandom_range(2, 7));
   endfunction

   // Random rounds: a new configuration, a few reloaded cells with mostly open walls, a
   // restart, then a long walk with some noise mixed in.
   task automatic test_random_mazes();
      int                    target;
      int                    walk_len;
      int                    roll;
      logic [4:0]            rows_v;
      logic [4:0]            cols_v;
      logic [POS_W-1:0]      srow_v;
      logic [POS_W-1:0]      scol_v;
      logic [CSR_DATA_W-1:0] goals_v;
      target = words_sent + RANDOM_WORDS;
      while (words_sent < target) begin
         rows_v  = pick_extent();
         cols_v  = pick_extent();
         goals_v = $urandom;
         wait_drain();
         // The predictor copy gives the sizes in use for picking cells inside the maze.
         csr_write(CSR_MAZE_ROWS, {27'($urandom), rows_v});
         csr_write(CSR_MAZE_COLS, {27'($urandom), cols_v});
         srow_v = ($urandom_range(0, 3) == 0) ? 4'($urandom)
                                              : 4'($urandom_range(0, rows_in_use() - 1));
         scol_v = ($urandom_range(0, 3) == 0) ? 4'($urandom)
                                              : 4'($urandom_range(0, cols_in_use() - 1));
         // Most rounds put one goal inside the maze so that walks can end on it.
         if ($urandom_range(0, 9) < 7) begin
            goals_v[7:0] = {4'($urandom_range(0, rows_in_use() - 1)),
                            4'($urandom_range(0, cols_in_use() - 1))};
         end
         set_maze(rows_v, cols_v, srow_v, scol_v, goals_v);
         // Some rounds walk first from wherever the last round left the walker.
         if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) send_cmd(F_STEP);
         repeat ($urandom_range(0, 10)) begin
            send_word(F_LOAD, 4'($urandom_range(0, rows_in_use() - 1)),
                      4'($urandom_range(0, cols_in_use() - 1)),
                      $urandom_range(0, 2) == 0, $urandom_range(0, 2) == 0);
         end
         send_cmd(F_RESTART);
         walk_len = $urandom_range(15, 60);
         repeat (walk_len) begin
            roll = $urandom_range(0, 29);
            if (roll == 0) begin
               send_cmd(F_UNUSED);
            end else if (roll == 1) begin
               send_word(F_LOAD, 4'($urandom), 4'($urandom),
                         $urandom_range(0, 2) == 0, $urandom_range(0, 2) == 0);
            end else if (roll == 2) begin
               send_cmd(F_RESTART);
            end else begin
               // Once in a while the sender holds off until the block has answered everything.
               if (roll == 3) wait_drain();
               send_cmd(F_STEP);
            end
         end
      end
   endtask

   initial begin
      cfg_rows      = MAZE_ROWS_RST;
      cfg_cols      = MAZE_COLS_RST;
      cfg_start_row = START_ROW_RST;
      cfg_start_col = START_COL_RST;
      cfg_goals     = GOAL_CELLS_RST;
      walk_row      = '0;
      walk_col      = '0;
      walk_dir      = DIR_E;
      walk_steps    = '0;
      for (int i = 0; i < 256; i++) wall_bits[i] = 2'b00;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_fill_map();
      test_step_from_reset();
      test_unused_func();
      test_rule_moves();
      test_tiny_maze();
      test_size_saturation();
      test_start_clamp();
      test_goal_hold();
      test_shrink_under_walker();
      test_random_mazes();

      wait_drain();
      pause(TAIL_CYCLES);
      if (mismatch_count == 0 && pending_views.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // The whole run needs well under a tenth of this time.
   initial begin
      #5000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

/* sim.f */
+incdir+sv
sv/rhwf_pkg.sv
sv/rhwf_ctrl.sv
sv/rhwf_dp.sv
sv/right_hand_wall_follower.sv
sv/rhwf_checker.sv
bench/testbench.sv
